### rtl/core/ernn_pkg.sv
// shared constants, types and the tanh table of the elman cell
package ernn_pkg;

   localparam int FEATURES         = 5;
   localparam int HIDDEN_UNITS     = 4;
   localparam int TANH_TABLE_DEPTH = 256;

   localparam int FEATURE_W = 32;
   localparam int WEIGHT_W  = 16;
   localparam int HIDDEN_W  = 16;
   localparam int PROD_W    = FEATURE_W + WEIGHT_W;
   localparam int ACC_W     = 52;

   localparam int REC_W_BASE   = FEATURES * HIDDEN_UNITS;
   localparam int OUT_W_BASE   = REC_W_BASE + HIDDEN_UNITS * HIDDEN_UNITS;
   localparam int HID_B_BASE   = OUT_W_BASE + HIDDEN_UNITS;
   localparam int OUT_B_INDEX  = HID_B_BASE + HIDDEN_UNITS;
   localparam int WEIGHT_WORDS = OUT_B_INDEX + 1;

   localparam int WADDR_W    = $clog2(WEIGHT_WORDS);
   localparam int HID_IDX_W  = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
   localparam int HID_ADDR_W = $clog2(2 * HIDDEN_UNITS);
   localparam int FEAT_IDX_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
   localparam int TERMS_HID  = 1 + FEATURES + HIDDEN_UNITS;
   localparam int TERMS_OUT  = 1 + HIDDEN_UNITS;
   localparam int TERM_W     = $clog2(TERMS_HID);
   localparam int TIDX_W     = $clog2(TANH_TABLE_DEPTH);

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [2:0] TERM_BIAS_H = 3'd0;
   localparam logic [2:0] TERM_X      = 3'd1;
   localparam logic [2:0] TERM_REC    = 3'd2;
   localparam logic [2:0] TERM_BIAS_O = 3'd3;
   localparam logic [2:0] TERM_OUT    = 3'd4;

   localparam logic signed [FEATURE_W-1:0] BIAS_H_SCALE = 32'sd65536;
   localparam logic signed [FEATURE_W-1:0] BIAS_O_SCALE = 32'sd32768;
   localparam logic signed [ACC_W-1:0]     TANH_LIM     = ACC_W'(64'd1 << 32);
   localparam logic signed [ACC_W-1:0]     ROUND_BIAS   = ACC_W'(4096);
   localparam int                          ROUND_SHIFT  = 13;
   localparam logic signed [31:0]          PRED_MAX     = 32'sh7fffffff;
   localparam logic signed [31:0]          PRED_MIN     = 32'sh80000000;

   typedef logic signed [FEATURE_W-1:0] feature_type;
   typedef feature_type                 feature_array_type [FEATURES];
   typedef logic signed [WEIGHT_W-1:0]  weight_type;
   typedef logic signed [HIDDEN_W-1:0]  hidden_type;
   typedef logic [TANH_TABLE_DEPTH-1:0][HIDDEN_W-1:0] tanh_table_type;

   typedef struct packed {
      logic                  valid;
      logic [2:0]            kind;
      logic                  first;
      logic                  last_hid;
      logic                  last_out;
      logic [FEAT_IDX_W-1:0] feat;
      logic [HID_ADDR_W-1:0] hw_addr;
   } term_tag_type;

   typedef struct packed {
      logic [WADDR_W-1:0]    w_addr;
      logic [HID_ADDR_W-1:0] h_addr;
   } rd_req_type;

   typedef struct packed {
      logic               en;
      logic [WADDR_W-1:0] addr;
      weight_type         data;
   } wgt_wr_type;

   typedef struct packed {
      logic                  en;
      logic [HID_ADDR_W-1:0] addr;
      hidden_type            data;
   } hid_wr_type;

   typedef struct packed {
      logic               valid;
      logic signed [31:0] prediction;
      logic               clipped;
   } result_type;

   function automatic logic [HID_ADDR_W-1:0] hid_addr_f(input logic bank,
                                                        input logic [HID_IDX_W-1:0] j);
      if (bank)
         return HID_ADDR_W'(HIDDEN_UNITS) + HID_ADDR_W'(j);
      return HID_ADDR_W'(j);
   endfunction

   // tanh at the midpoint of cell k, e^-a by series and eight squarings
   function automatic logic [HIDDEN_W-1:0] tanh_entry_f(input int unsigned k);
      logic signed [63:0] num;
      logic               neg;
      logic [63:0]        mag;
      logic [63:0]        b;
      logic [63:0]        b2;
      logic [63:0]        b3;
      logic [63:0]        e;
      logic [63:0]        v;
      logic [63:0]        den;
      logic [63:0]        rem;
      logic [63:0]        q;
      int                 n;
      num = $signed(64'(8 * k + 4)) - $signed(64'(4 * TANH_TABLE_DEPTH));
      neg = num[63];
      mag = neg ? 64'(-num) : 64'(num);
      b   = (mag << 25) / TANH_TABLE_DEPTH;
      b2  = (b * b) >> 32;
      b3  = (b2 * b) >> 32;
      e   = (64'd1 << 32) - b + (b2 >> 1) - b3 / 64'd6;
      v   = (e + 64'd1) >> 1;
      for (n = 0; n < 8; n++)
         v = (v * v + (64'd1 << 30)) >> 31;
      den = (64'd1 << 31) + v;
      rem = ((64'd1 << 31) - v) * 64'd32768 + (den >> 1);
      q   = '0;
      // restoring long division
      for (n = 16; n >= 0; n--) begin
         if (rem >= (den << n)) begin
            rem  = rem - (den << n);
            q[n] = 1'b1;
         end
      end
      if (q > 64'd32767)
         q = 64'd32767;
      return neg ? HIDDEN_W'(-q) : HIDDEN_W'(q);
   endfunction

   function automatic tanh_table_type tanh_table_f();
      tanh_table_type t;
      int unsigned    k;
      for (k = 0; k < TANH_TABLE_DEPTH; k++)
         t[k] = tanh_entry_f(k);
      return t;
   endfunction

   localparam tanh_table_type TANH_TABLE = tanh_table_f();

endpackage

### rtl/core/elman_rnn_cell_inference.sv
// elman rnn cell with tanh hidden layer, inference top level
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  cmd, weight_index, weight_value, feature_a..e
//   rsp      out        rsp_valid / rsp_stall  prediction, clipped
//
// a weight write or a hidden clear gives no result
// a run is paced by one multiply-accumulate term issued per cycle from the weight memory port
// the next item is taken once the result has moved to the output register
// reset clears the hidden vector valid bits at once; the weight memory is not cleared
// rsp_stall holds the output register; a new run result waits behind it
module elman_rnn_cell_inference import ernn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [5:0]         req_weight_index,
   input  logic signed [15:0] req_weight_value,
   input  logic signed [31:0] req_feature_a,
   input  logic signed [31:0] req_feature_b,
   input  logic signed [31:0] req_feature_c,
   input  logic signed [31:0] req_feature_d,
   input  logic signed [31:0] req_feature_e,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_prediction,
   output logic               rsp_clipped
);

   localparam int FEAT_VEC_W = FEATURES * FEATURE_W;

   logic                  busy;
   logic                  req_xfer;
   logic                  start;
   logic                  hid_clear;
   logic                  out_take;
   wgt_wr_type            wgt_wr;
   hid_wr_type            hid_wr;
   rd_req_type            rd_req;
   term_tag_type          tag;
   weight_type            w_data;
   hidden_type            h_data;
   result_type            result;
   logic [FEAT_VEC_W-1:0] feat_vec;
   feature_array_type     features;

   logic                  rsp_valid_ff;
   logic signed [31:0]    rsp_prediction_ff;
   logic                  rsp_clipped_ff;

   assign req_stall = busy;
   assign req_xfer  = req_valid && !req_stall;
   assign start     = req_xfer && (req_cmd == CMD_RUN);
   assign hid_clear = req_xfer && (req_cmd == CMD_CLEAR);

   assign wgt_wr.en   = req_xfer && (req_cmd == CMD_WRITE)
                      && (32'(req_weight_index) < WEIGHT_WORDS);
   assign wgt_wr.addr = WADDR_W'(req_weight_index);
   assign wgt_wr.data = req_weight_value;

   assign feat_vec = FEAT_VEC_W'({req_feature_e, req_feature_d, req_feature_c,
                                  req_feature_b, req_feature_a});

   always_comb begin
      for (int j = 0; j < FEATURES; j++)
         features[j] = feat_vec[j*FEATURE_W +: FEATURE_W];
   end

   ernn_store u_store (
      .clock     (clock),
      .reset     (reset),
      .wgt_wr    (wgt_wr),
      .hid_wr    (hid_wr),
      .hid_clear (hid_clear),
      .rd_req    (rd_req),
      .w_data    (w_data),
      .h_data    (h_data)
   );

   ernn_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_take (out_take),
      .busy     (busy),
      .rd_req   (rd_req),
      .tag      (tag)
   );

   ernn_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .feat_load (start),
      .features  (features),
      .tag       (tag),
      .w_data    (w_data),
      .h_data    (h_data),
      .out_take  (out_take),
      .hid_wr    (hid_wr),
      .result    (result)
   );

   assign out_take = result.valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (out_take)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         rsp_prediction_ff <= result.prediction;
         rsp_clipped_ff    <= result.clipped;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prediction = rsp_prediction_ff;
   assign rsp_clipped    = rsp_clipped_ff;

endmodule

### rtl/core/ernn_store.sv
// weight memory and double-banked hidden vector memory
module ernn_store import ernn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  wgt_wr_type wgt_wr,
   input  hid_wr_type hid_wr,
   input  logic       hid_clear,
   input  rd_req_type rd_req,
   output weight_type w_data,
   output hidden_type h_data
);

   weight_type wgt_mem [WEIGHT_WORDS];
   hidden_type hid_mem [2 * HIDDEN_UNITS];

   logic [2*HIDDEN_UNITS-1:0] hid_valid_ff;
   logic [2*HIDDEN_UNITS-1:0] hid_valid_in;
   weight_type                w_q_ff;
   hidden_type                h_q_ff;
   logic                      h_ok_ff;

   always_ff @(posedge clock) begin
      if (wgt_wr.en)
         wgt_mem[wgt_wr.addr] <= wgt_wr.data;
      w_q_ff <= wgt_mem[rd_req.w_addr];
   end

   always_ff @(posedge clock) begin
      if (hid_wr.en)
         hid_mem[hid_wr.addr] <= hid_wr.data;
      h_q_ff  <= hid_mem[rd_req.h_addr];
      h_ok_ff <= hid_valid_ff[rd_req.h_addr];
   end

   // entries not written since reset or clear read as zero
   always_comb begin
      hid_valid_in = hid_valid_ff;
      if (hid_clear)
         hid_valid_in = '0;
      if (hid_wr.en)
         hid_valid_in[hid_wr.addr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         hid_valid_ff <= '0;
      else
         hid_valid_ff <= hid_valid_in;
   end

   assign w_data = w_q_ff;
   assign h_data = h_ok_ff ? h_q_ff : '0;

endmodule

### rtl/core/ernn_seq.sv
// sequencer issuing one multiply-accumulate term per cycle in its hidden and output states
module ernn_seq import ernn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         out_take,
   output logic         busy,
   output rd_req_type   rd_req,
   output term_tag_type tag
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_HID  = 3'd1;
   localparam logic [2:0] S_GAP  = 3'd2;
   localparam logic [2:0] S_OUT  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0]           state_ff;
   logic [2:0]           state_in;
   logic [HID_IDX_W-1:0] unit_ff;
   logic [HID_IDX_W-1:0] unit_in;
   logic [TERM_W-1:0]    term_ff;
   logic [TERM_W-1:0]    term_in;
   logic                 bank_ff;
   logic                 bank_in;
   logic [TERM_W-1:0]    term_m1;
   logic [TERM_W-1:0]    rec_j;

   assign term_m1 = term_ff - TERM_W'(1);
   assign rec_j   = term_ff - TERM_W'(1 + FEATURES);

   always_comb begin
      state_in = state_ff;
      unit_in  = unit_ff;
      term_in  = term_ff;
      bank_in  = bank_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_HID;
               unit_in  = '0;
               term_in  = '0;
            end
         end
         S_HID: begin
            if (term_ff == TERM_W'(TERMS_HID - 1)) begin
               term_in = '0;
               if (unit_ff == HID_IDX_W'(HIDDEN_UNITS - 1))
                  state_in = S_GAP;
               else
                  unit_in = unit_ff + HID_IDX_W'(1);
            end else begin
               term_in = term_ff + TERM_W'(1);
            end
         end
         S_GAP: begin
            state_in = S_OUT;
            term_in  = '0;
         end
         S_OUT: begin
            if (term_ff == TERM_W'(TERMS_OUT - 1))
               state_in = S_FIN;
            else
               term_in = term_ff + TERM_W'(1);
         end
         S_FIN: begin
            if (out_take) begin
               state_in = S_IDLE;
               bank_in  = !bank_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rd_req = '0;
      tag    = '0;
      case (state_ff)
         S_HID: begin
            tag.valid    = 1'b1;
            tag.first    = (term_ff == '0);
            tag.last_hid = (term_ff == TERM_W'(TERMS_HID - 1));
            tag.hw_addr  = hid_addr_f(!bank_ff, unit_ff);
            if (term_ff == '0) begin
               tag.kind      = TERM_BIAS_H;
               rd_req.w_addr = WADDR_W'(HID_B_BASE) + WADDR_W'(unit_ff);
            end else if (term_ff <= TERM_W'(FEATURES)) begin
               tag.kind      = TERM_X;
               tag.feat      = FEAT_IDX_W'(term_m1);
               rd_req.w_addr = WADDR_W'(term_m1) * WADDR_W'(HIDDEN_UNITS)
                             + WADDR_W'(unit_ff);
            end else begin
               tag.kind      = TERM_REC;
               rd_req.w_addr = WADDR_W'(REC_W_BASE)
                             + WADDR_W'(rec_j) * WADDR_W'(HIDDEN_UNITS)
                             + WADDR_W'(unit_ff);
               rd_req.h_addr = hid_addr_f(bank_ff, HID_IDX_W'(rec_j));
            end
         end
         S_OUT: begin
            tag.valid    = 1'b1;
            tag.first    = (term_ff == '0);
            tag.last_out = (term_ff == TERM_W'(TERMS_OUT - 1));
            if (term_ff == '0) begin
               tag.kind      = TERM_BIAS_O;
               rd_req.w_addr = WADDR_W'(OUT_B_INDEX);
            end else begin
               tag.kind      = TERM_OUT;
               rd_req.w_addr = WADDR_W'(OUT_W_BASE) + WADDR_W'(term_m1);
               rd_req.h_addr = hid_addr_f(!bank_ff, HID_IDX_W'(term_m1));
            end
         end
         default: begin
            rd_req = '0;
            tag    = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         unit_ff  <= '0;
         term_ff  <= '0;
         bank_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         unit_ff  <= unit_in;
         term_ff  <= term_in;
         bank_ff  <= bank_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### rtl/core/ernn_mac.sv
// shared multiply-accumulate pipeline with tanh lookup and output rounding
module ernn_mac import ernn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              feat_load,
   input  feature_array_type features,
   input  term_tag_type      tag,
   input  weight_type        w_data,
   input  hidden_type        h_data,
   input  logic              out_take,
   output hid_wr_type        hid_wr,
   output result_type        result
);

   localparam int SCALED_W = 33 + TIDX_W;

   feature_array_type         x_ff;
   term_tag_type              tag1_ff;
   term_tag_type              tag2_ff;
   term_tag_type              tag3_ff;
   feature_type               op_a;
   logic signed [PROD_W-1:0]  prod;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;

   logic                      below;
   logic                      above;
   logic [32:0]               offset;
   logic [SCALED_W-1:0]       scaled;
   logic [TIDX_W-1:0]         idx_in;
   logic [TIDX_W-1:0]         idx_ff;
   logic                      idx_v_ff;
   logic [HID_ADDR_W-1:0]     idx_addr_ff;
   hidden_type                th_ff;
   logic                      th_v_ff;
   logic [HID_ADDR_W-1:0]     th_addr_ff;

   logic signed [ACC_W-1:0]   rnd_sum;
   logic signed [ACC_W-1:0]   rnd;
   logic                      fits;
   logic signed [31:0]        pred_in;
   logic                      out_v_ff;
   logic signed [31:0]        pred_ff;
   logic                      clip_ff;

   always_ff @(posedge clock) begin
      if (feat_load)
         x_ff <= features;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   // operand select and product
   always_comb begin
      case (tag1_ff.kind)
         TERM_X:      op_a = x_ff[tag1_ff.feat];
         TERM_REC:    op_a = FEATURE_W'(h_data) <<< 1;
         TERM_OUT:    op_a = FEATURE_W'(h_data);
         TERM_BIAS_H: op_a = BIAS_H_SCALE;
         TERM_BIAS_O: op_a = BIAS_O_SCALE;
         default:     op_a = '0;
      endcase
   end

   assign prod = op_a * w_data;

   always_ff @(posedge clock) begin
      prod_ff <= prod;
   end

   assign acc_in = (tag2_ff.first ? '0 : acc_ff) + ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (tag2_ff.valid)
         acc_ff <= acc_in;
   end

   // tanh table index
   assign below  = (acc_ff < -TANH_LIM);
   assign above  = (acc_ff >= TANH_LIM);
   assign offset = 33'(acc_ff + TANH_LIM);
   assign scaled = SCALED_W'(offset) * SCALED_W'(TANH_TABLE_DEPTH);

   always_comb begin
      if (below)
         idx_in = '0;
      else if (above)
         idx_in = TIDX_W'(TANH_TABLE_DEPTH - 1);
      else
         idx_in = scaled[SCALED_W-1:33];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_v_ff <= 1'b0;
         th_v_ff  <= 1'b0;
      end else begin
         idx_v_ff <= tag3_ff.valid && tag3_ff.last_hid;
         th_v_ff  <= idx_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      idx_addr_ff <= tag3_ff.hw_addr;
      th_ff       <= hidden_type'(TANH_TABLE[idx_ff]);
      th_addr_ff  <= idx_addr_ff;
   end

   assign hid_wr.en   = th_v_ff;
   assign hid_wr.addr = th_addr_ff;
   assign hid_wr.data = th_ff;

   // round half up to q16.16 and saturate
   assign rnd_sum = acc_ff + ROUND_BIAS;
   assign rnd     = rnd_sum >>> ROUND_SHIFT;
   assign fits    = (&rnd[ACC_W-1:31]) || !(|rnd[ACC_W-1:31]);

   always_comb begin
      if (fits)
         pred_in = rnd[31:0];
      else if (rnd[ACC_W-1])
         pred_in = PRED_MIN;
      else
         pred_in = PRED_MAX;
   end

   always_ff @(posedge clock) begin
      if (reset)
         out_v_ff <= 1'b0;
      else if (tag3_ff.valid && tag3_ff.last_out)
         out_v_ff <= 1'b1;
      else if (out_take)
         out_v_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (tag3_ff.valid && tag3_ff.last_out) begin
         pred_ff <= pred_in;
         clip_ff <= !fits;
      end
   end

   assign result.valid      = out_v_ff;
   assign result.prediction = pred_ff;
   assign result.clipped    = clip_ff;

endmodule

### rtl/core/ernn_checker.sv
// port-level checks for the elman cell top level
module ernn_checker import ernn_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [1:0]         req_cmd,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_prediction,
   input logic               rsp_clipped
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_prediction) && $stable(rsp_clipped))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a run transfer keeps the input side busy
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd == CMD_RUN |=> req_stall)
      else $error("run transfer did not occupy the block");

   // a fresh result only comes out of a run in progress
   a_rsp_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a run");

   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> rsp_prediction == PRED_MAX || rsp_prediction == PRED_MIN)
      else $error("clipped result not at a range limit");

endmodule

bind elman_rnn_cell_inference ernn_checker u_checker (.*);
